FILE: src/fixed_point_alu_q24_8_defines.svh
// Assertion macros for the fixed-point ALU.
// No dependencies; included by files that carry concurrent checks.
`ifndef FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define FPA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
// Implication with a fixed cycle delay, disabled during reset.
`define FPA_ASSERT_DLY(lbl, ck, rn, ante, n, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##(n) (cons)) \
        else $error(msg);
`else
`define FPA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define FPA_ASSERT_DLY(lbl, ck, rn, ante, n, cons, msg)
`endif

`endif

FILE: src/fpa_pkg.sv
// Shared types, constants and the saturation helper of the fixed-point ALU.
// No dependencies.
package fpa_pkg;

    localparam int WORD_W            = 32;
    localparam int MAG_W             = 64;
    localparam int DEFAULT_FRAC_BITS = 8;

    localparam logic [WORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [3:0] {
        MODE_ADD    = 4'd0,
        MODE_SUB    = 4'd1,
        MODE_MUL    = 4'd2,
        MODE_DIV    = 4'd3,
        MODE_LT     = 4'd4,
        MODE_GT     = 4'd5,
        MODE_LE     = 4'd6,
        MODE_GE     = 4'd7,
        MODE_EQ     = 4'd8,
        MODE_NE     = 4'd9,
        MODE_MIN    = 4'd10,
        MODE_MAX    = 4'd11,
        MODE_INC    = 4'd12,
        MODE_DEC    = 4'd13,
        MODE_TO_INT = 4'd14
    } mode_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              cmp;
        logic              ovf;
        logic              dz;
    } result_t;

    // Front stage control: request valid, mode and the result of the short ops.
    typedef struct packed {
        logic    valid;
        mode_t   mode;
        result_t res;
    } ctrl_t;

    // Operands prepared for the multiplier and divider.
    typedef struct packed {
        logic              mul_valid;
        logic              div_valid;
        logic [WORD_W-1:0] mag_a;
        logic [WORD_W-1:0] mag_b;
        logic              neg;
        logic              a_neg;
        logic              b_zero;
    } opnd_t;

    // Sign plus magnitude to a saturated 32-bit word.
    function automatic result_t sat_signmag(input logic neg, input logic [MAG_W-1:0] mag);
        result_t r;
        r = '0;
        if (neg) begin
            if (mag > MAG_W'(NEG_LIMIT)) begin
                r.ovf   = 1'b1;
                r.value = NEG_LIMIT;
            end else begin
                r.value = ~mag[WORD_W-1:0] + 1'b1;
            end
        end else begin
            if (mag > MAG_W'(POS_LIMIT)) begin
                r.ovf   = 1'b1;
                r.value = POS_LIMIT;
            end else begin
                r.value = mag[WORD_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

FILE: src/fixed_point_alu_q24_8.sv
// Signed fixed-point ALU, 32-bit words with FRAC_BITS fraction bits (Q24.8 by
// default). A request is taken on every clock edge where start is high; busy
// is always low, so a new request may follow in each cycle. Every request
// gives exactly one result, presented for one cycle with done high, in
// request order. The divider is the longest path: one quotient bit per
// stage over 32 + FRAC_BITS stages, plus an input stage, a rounding stage
// and the output register. All modes take that same path length; the short
// ops and the multiplier wait in delay lines. The receiver has no way to
// hold results off, so it must take done whenever it appears.
// Depends on fpa_pkg, fpa_front, fpa_mul, fpa_div, fpa_delay and the macro header.
`include "fixed_point_alu_q24_8_defines.svh"

module fixed_point_alu_q24_8 #(
    parameter int FRAC_BITS = fpa_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [3:0]                        mode,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_b,
    output logic                              done,
    output logic signed [fpa_pkg::WORD_W-1:0] result_value,
    output logic                              compare_true,
    output logic                              overflow,
    output logic                              divide_by_zero
);

    localparam int NUM_W   = fpa_pkg::WORD_W + FRAC_BITS;
    // cycles from the front register to the aligned results
    localparam int DIV_LAT = NUM_W + 1;
    localparam int MUL_LAT = 2;
    localparam int LATENCY = DIV_LAT + 2;
    localparam int RES_W   = $bits(fpa_pkg::result_t);
    localparam int CTRL_W  = $bits(fpa_pkg::mode_t) + RES_W;

    fpa_pkg::ctrl_t   ctrl;
    fpa_pkg::opnd_t   opnd;

    logic             mul_valid;
    fpa_pkg::result_t mul_res;
    logic             div_valid;
    fpa_pkg::result_t div_res;

    logic             ctrl_dly_valid;
    logic [CTRL_W-1:0] ctrl_dly_data;
    fpa_pkg::mode_t   ctrl_dly_mode;
    fpa_pkg::result_t ctrl_dly_res;

    logic             mul_dly_valid;
    logic [RES_W-1:0] mul_dly_data;

    fpa_pkg::result_t out_next;
    fpa_pkg::result_t out_reg;
    logic             done_reg;

    // Never stalls: the pipeline takes one request per cycle.
    assign busy = 1'b0;

    // Stage 1: input register, short ops, operand magnitudes.
    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .mode      (mode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ctrl      (ctrl),
        .opnd      (opnd)
    );

    // Multiplier: two stages behind the front register.
    fpa_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .opnd      (opnd),
        .res_valid (mul_valid),
        .res       (mul_res)
    );

    // Divider: NUM_W bit stages plus rounding; sets the overall latency.
    fpa_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .opnd      (opnd),
        .res_valid (div_valid),
        .res       (div_res)
    );

    // Short-op results and request valid wait for the divider.
    fpa_delay #(
        .DEPTH (DIV_LAT),
        .WIDTH (CTRL_W)
    ) u_ctrl_dly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ctrl.valid),
        .in_data   ({ctrl.mode, ctrl.res}),
        .out_valid (ctrl_dly_valid),
        .out_data  (ctrl_dly_data)
    );

    // Multiplier results wait for the remaining divider stages.
    fpa_delay #(
        .DEPTH (DIV_LAT - MUL_LAT),
        .WIDTH (RES_W)
    ) u_mul_dly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_data   (mul_res),
        .out_valid (mul_dly_valid),
        .out_data  (mul_dly_data)
    );

    // Merge the three aligned paths; the long-op valids pick their branch.
    always_comb
    begin
        ctrl_dly_mode = fpa_pkg::mode_t'(ctrl_dly_data[CTRL_W-1:RES_W]);
        ctrl_dly_res  = ctrl_dly_data[RES_W-1:0];
        if (mul_dly_valid)
        begin
            out_next = mul_dly_data;
        end
        else if (div_valid)
        begin
            out_next = div_res;
        end
        else
        begin
            out_next = ctrl_dly_res;
        end
    end

    // Output register: one-cycle result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_dly_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done           = done_reg;
    assign result_value   = out_reg.value;
    assign compare_true   = out_reg.cmp;
    assign overflow       = out_reg.ovf;
    assign divide_by_zero = out_reg.dz;

    // Long-op paths must line up with the request they belong to.
    `FPA_ASSERT_IMP(a_mul_align, clk, rst_n, 1'b1,
        mul_dly_valid == (ctrl_dly_valid && ctrl_dly_mode == fpa_pkg::MODE_MUL),
        "multiplier result out of step with its request")
    `FPA_ASSERT_IMP(a_div_align, clk, rst_n, 1'b1,
        div_valid == (ctrl_dly_valid && ctrl_dly_mode == fpa_pkg::MODE_DIV),
        "divider result out of step with its request")
    `FPA_ASSERT_DLY(a_latency, clk, rst_n, start, LATENCY, done,
        "request did not produce a result at the fixed latency")
    `FPA_ASSERT_IMP(a_flags, clk, rst_n, done,
        !(overflow && divide_by_zero) && !(compare_true && result_value != '0),
        "inconsistent result flags")

endmodule

FILE: src/fpa_front.sv
// Input register stage: short ops (add/sub/inc/dec, compares, min/max, to_int)
// and operand magnitudes for the long ops. Depends on fpa_pkg.
module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [3:0]                         mode,
    input  logic signed [fpa_pkg::WORD_W-1:0]  operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0]  operand_b,
    output fpa_pkg::ctrl_t                     ctrl,
    output fpa_pkg::opnd_t                     opnd
);

    localparam int W = fpa_pkg::WORD_W;

    fpa_pkg::mode_t   mode_in;
    logic signed [W:0] a_ext;
    logic signed [W:0] y_ext;
    logic signed [W:0] sum_ext;
    logic              a_neg;
    logic              b_neg;
    logic              lt;
    logic              eq;
    logic [W-1:0]      mag_a;
    logic [W-1:0]      mag_b;
    logic [W-1:0]      int_mag;
    fpa_pkg::result_t  simple;

    logic              valid_reg;
    fpa_pkg::mode_t    mode_reg;
    fpa_pkg::result_t  res_reg;
    logic              mul_valid_reg;
    logic              div_valid_reg;
    logic [W-1:0]      mag_a_reg;
    logic [W-1:0]      mag_b_reg;
    logic              neg_reg;
    logic              a_neg_reg;
    logic              b_zero_reg;

    always_comb
    begin
        mode_in = fpa_pkg::mode_t'(mode);
        a_neg   = operand_a[W-1];
        b_neg   = operand_b[W-1];
        a_ext   = $signed({operand_a[W-1], operand_a});
        case (mode_in)
            fpa_pkg::MODE_SUB: y_ext = -$signed({operand_b[W-1], operand_b});
            fpa_pkg::MODE_INC: y_ext = (W+1)'(1);
            fpa_pkg::MODE_DEC: y_ext = -$signed((W+1)'(1));
            default:           y_ext = $signed({operand_b[W-1], operand_b});
        endcase
        sum_ext = a_ext + y_ext;

        lt      = operand_a < operand_b;
        eq      = operand_a == operand_b;
        mag_a   = a_neg ? W'(-operand_a) : W'(operand_a);
        mag_b   = b_neg ? W'(-operand_b) : W'(operand_b);
        int_mag = mag_a >> FRAC_BITS;

        simple = '0;
        case (mode_in)
            fpa_pkg::MODE_ADD, fpa_pkg::MODE_SUB, fpa_pkg::MODE_INC, fpa_pkg::MODE_DEC:
            begin
                // 33-bit sum leaves range when its top two bits differ
                if (sum_ext[W] != sum_ext[W-1])
                begin
                    simple.ovf   = 1'b1;
                    simple.value = sum_ext[W] ? fpa_pkg::NEG_LIMIT : fpa_pkg::POS_LIMIT;
                end
                else
                begin
                    simple.value = sum_ext[W-1:0];
                end
            end
            fpa_pkg::MODE_LT:     simple.cmp = lt;
            fpa_pkg::MODE_GT:     simple.cmp = !lt && !eq;
            fpa_pkg::MODE_LE:     simple.cmp = lt || eq;
            fpa_pkg::MODE_GE:     simple.cmp = !lt;
            fpa_pkg::MODE_EQ:     simple.cmp = eq;
            fpa_pkg::MODE_NE:     simple.cmp = !eq;
            fpa_pkg::MODE_MIN:    simple.value = lt ? operand_a : operand_b;
            fpa_pkg::MODE_MAX:    simple.value = (!lt && !eq) ? operand_a : operand_b;
            fpa_pkg::MODE_TO_INT: simple.value = a_neg ? (~int_mag + 1'b1) : int_mag;
            default:              simple = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            mul_valid_reg <= 1'b0;
            div_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= in_valid;
            mul_valid_reg <= in_valid && (mode_in == fpa_pkg::MODE_MUL);
            div_valid_reg <= in_valid && (mode_in == fpa_pkg::MODE_DIV);
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_in;
        res_reg    <= simple;
        mag_a_reg  <= mag_a;
        mag_b_reg  <= mag_b;
        neg_reg    <= a_neg ^ b_neg;
        a_neg_reg  <= a_neg;
        b_zero_reg <= (operand_b == '0);
    end

    assign ctrl.valid     = valid_reg;
    assign ctrl.mode      = mode_reg;
    assign ctrl.res       = res_reg;
    assign opnd.mul_valid = mul_valid_reg;
    assign opnd.div_valid = div_valid_reg;
    assign opnd.mag_a     = mag_a_reg;
    assign opnd.mag_b     = mag_b_reg;
    assign opnd.neg       = neg_reg;
    assign opnd.a_neg     = a_neg_reg;
    assign opnd.b_zero    = b_zero_reg;

endmodule

FILE: src/fpa_mul.sv
// Two-stage multiplier: 32x32 magnitude product, then round half away from
// zero, scale and saturate. Depends on fpa_pkg.
module fpa_mul #(
    parameter int FRAC_BITS = fpa_pkg::DEFAULT_FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fpa_pkg::opnd_t   opnd,
    output logic             res_valid,
    output fpa_pkg::result_t res
);

    localparam int                         PROD_W    = fpa_pkg::MAG_W;
    localparam logic [PROD_W-1:0]          ROUND_ONE = PROD_W'(1) << (FRAC_BITS - 1);

    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    logic              valid_reg;
    logic [PROD_W-1:0] rounded;
    fpa_pkg::result_t  sat;
    fpa_pkg::result_t  res_reg;
    logic              res_valid_reg;

    always_comb
    begin
        rounded = (prod_reg + ROUND_ONE) >> FRAC_BITS;
        sat     = fpa_pkg::sat_signmag(neg_reg && (rounded != '0), rounded);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= opnd.mul_valid;
            res_valid_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opnd.mag_a * opnd.mag_b;
        neg_reg  <= opnd.neg;
        res_reg  <= sat;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: src/fpa_div.sv
// Pipelined restoring divider, one quotient bit per stage, then a round and
// saturate stage. Depends on fpa_pkg.
module fpa_div #(
    parameter int FRAC_BITS = fpa_pkg::DEFAULT_FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fpa_pkg::opnd_t   opnd,
    output logic             res_valid,
    output fpa_pkg::result_t res
);

    localparam int W     = fpa_pkg::WORD_W;
    localparam int NUM_W = W + FRAC_BITS;

    // per-stage state: partial remainder, dividend bits merged with quotient bits
    logic [W-1:0]     rem_reg [NUM_W];
    logic [NUM_W-1:0] dq_reg  [NUM_W];
    logic [W-1:0]     den_reg [NUM_W];
    logic [NUM_W-1:0] neg_reg;
    logic [NUM_W-1:0] a_neg_reg;
    logic [NUM_W-1:0] zero_reg;
    logic [NUM_W-1:0] valid_reg;

    logic [W-1:0]     rem_in [NUM_W];
    logic [NUM_W-1:0] dq_in  [NUM_W];
    logic [W-1:0]     den_in [NUM_W];
    logic [NUM_W-1:0] neg_in;
    logic [NUM_W-1:0] a_neg_in;
    logic [NUM_W-1:0] zero_in;
    logic [NUM_W-1:0] valid_in;

    logic             round_up;
    logic [NUM_W:0]   quo_rnd;
    fpa_pkg::result_t fin;
    fpa_pkg::result_t res_reg;
    logic             res_valid_reg;

    always_comb
    begin
        rem_in[0]   = '0;
        dq_in[0]    = {opnd.mag_a, {FRAC_BITS{1'b0}}};
        den_in[0]   = opnd.mag_b;
        neg_in[0]   = opnd.neg;
        a_neg_in[0] = opnd.a_neg;
        zero_in[0]  = opnd.b_zero;
        valid_in[0] = opnd.div_valid;
        for (int i = 1; i < NUM_W; i++)
        begin
            rem_in[i]   = rem_reg[i-1];
            dq_in[i]    = dq_reg[i-1];
            den_in[i]   = den_reg[i-1];
            neg_in[i]   = neg_reg[i-1];
            a_neg_in[i] = a_neg_reg[i-1];
            zero_in[i]  = zero_reg[i-1];
            valid_in[i] = valid_reg[i-1];
        end
    end

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_step
        logic [W:0] trial;
        logic [W:0] diff;
        logic       take;

        always_comb
        begin
            trial = {rem_in[i], dq_in[i][NUM_W-1]};
            diff  = trial - {1'b0, den_in[i]};
            take  = !diff[W];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= valid_in[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]   <= take ? diff[W-1:0] : trial[W-1:0];
            dq_reg[i]    <= {dq_in[i][NUM_W-2:0], take};
            den_reg[i]   <= den_in[i];
            neg_reg[i]   <= neg_in[i];
            a_neg_reg[i] <= a_neg_in[i];
            zero_reg[i]  <= zero_in[i];
        end
    end

    // round to nearest: bump when twice the remainder reaches the divisor
    always_comb
    begin
        round_up = {rem_reg[NUM_W-1], 1'b0} >= {1'b0, den_reg[NUM_W-1]};
        quo_rnd  = {1'b0, dq_reg[NUM_W-1]} + (NUM_W+1)'(round_up);
        fin      = fpa_pkg::sat_signmag(neg_reg[NUM_W-1] && (quo_rnd != '0),
                                        fpa_pkg::MAG_W'(quo_rnd));
        if (zero_reg[NUM_W-1])
        begin
            fin       = '0;
            fin.dz    = 1'b1;
            fin.value = a_neg_reg[NUM_W-1] ? fpa_pkg::NEG_LIMIT : fpa_pkg::POS_LIMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= valid_reg[NUM_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= fin;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: src/fpa_delay.sv
// Fixed-length delay line with a reset valid bit beside each data stage.
// No dependencies.
module fpa_delay #(
    parameter int DEPTH = 1,
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= in_data;
        for (int i = 1; i < DEPTH; i++)
        begin
            data_reg[i] <= data_reg[i-1];
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule
